// ===== design/life_generation_row_stream_defines.svh =====
// ----------------------------------------------------------------------------
// Life generation row stream: assertion macros
// Shared concurrent assertion forms used by the row stream modules.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STREAM_DEFINES_SVH
`define LIFE_GENERATION_ROW_STREAM_DEFINES_SVH

// Check a condition at every clock edge outside reset
`define LGRS_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check a consequence in the same cycle as its trigger
`define LGRS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its trigger
`define LGRS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/lgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream package
// Widths, types and the B3/S23 cell rule shared by the row stream modules.
// ----------------------------------------------------------------------------
package lgrs_pkg;

  // Port row width and number of implemented columns
  localparam int ROW_W     = 64;
  localparam int ROW_CELLS = 64;

  // Width configuration register
  localparam int GW_W = 7;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Neighbor counts of the rule
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef logic [ROW_W-1:0] row_t;
  typedef logic [GW_W-1:0]  gw_t;
  localparam gw_t GW_RESET = gw_t'(ROW_W);

  // Masked bits one cell shows to its neighbors
  typedef struct packed {
    logic abv;  // row above the held row
    logic mid;  // held row
    logic cur;  // incoming row
  } nbr_t;

  // Per-transaction control broadcast to the cells
  typedef struct packed {
    logic accept;
    logic pending;
    logic last;
  } cell_ctl_t;

  // Per-cell results for both possible outputs
  typedef struct packed {
    logic nxt_a;   // next state of the held row
    logic diff_a;
    logic nxt_b;   // next state of the incoming row as bottom row
    logic diff_b;
  } cell_res_t;

  // One result transaction
  typedef struct packed {
    row_t next_row;
    logic row_changed;
    logic frame_changed;
    logic last_out;
  } out_entry_t;

  // Up to two results pushed per input transaction
  typedef struct packed {
    logic [1:0] cnt;
    out_entry_t ent0;
    out_entry_t ent1;
  } push_t;

  // Count the set bits of an eight-neighbor group
  function automatic logic [3:0] count_bits(input logic [7:0] bits);
    logic [3:0] sum;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, bits[i]};
    end
    return sum;
  endfunction

  // B3/S23: birth on three, survival on two or three
  function automatic logic life_rule(input logic alive, input logic [3:0] count);
    return (count == BIRTH_COUNT) || (alive && (count == SURVIVE_COUNT));
  endfunction

endpackage

// ===== design/lgrs_in_if.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream input channel
// Valid/ready channel carrying one grid row and its end-of-frame mark.
// ----------------------------------------------------------------------------
interface lgrs_in_if;
  import lgrs_pkg::*;

  logic valid;
  logic ready;
  row_t row_cells;
  logic last_row;

  modport source (output valid, output row_cells, output last_row, input ready);
  modport sink   (input valid, input row_cells, input last_row, output ready);
endinterface

// ===== design/lgrs_out_if.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream output channel
// Valid/ready channel carrying one next-generation row with its status flags.
// ----------------------------------------------------------------------------
interface lgrs_out_if;
  import lgrs_pkg::*;

  logic valid;
  logic ready;
  row_t next_row;
  logic row_changed;
  logic frame_changed;
  logic last_out;

  modport source (output valid, output next_row, output row_changed,
                  output frame_changed, output last_out, input ready);
  modport sink   (input valid, input next_row, input row_changed,
                  input frame_changed, input last_out, output ready);
endinterface

// ===== design/life_generation_row_stream.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream
// One B3/S23 generation over a grid streamed row by row, as a chain of
// column cells feeding a small result queue.
// ----------------------------------------------------------------------------
// A result is offered the cycle after its completing row is accepted if the queue was empty.
// Throughput: one row per cycle while the queue has room; a bottom row that
// follows a held row yields two results, queued together and sent in order.
// The input stalls only when the four-entry result queue holds over two rows.
// Reset: held rows and frame state clear, the width register returns to 64.
// ----------------------------------------------------------------------------
`include "life_generation_row_stream_defines.svh"

module life_generation_row_stream (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  lgrs_pkg::gw_t cfg_wdata_i,
  lgrs_in_if.sink       in_row,
  lgrs_out_if.source    out_row
);
  import lgrs_pkg::*;

  gw_t        gw_q;
  logic       pending_q, pending_d;
  logic       change_seen_q, change_seen_d;
  logic       accept;
  logic       room;
  logic       changed_a, changed_b;
  logic       seen_a, seen_b;
  cell_ctl_t  ctl;
  nbr_t       own [ROW_CELLS+2];
  cell_res_t  res [ROW_CELLS];
  row_t       nxt_a, nxt_b, diff_a, diff_b;
  out_entry_t ent_a, ent_b;
  push_t      push;

  assign in_row.ready = room;
  assign accept       = in_row.valid & room;
  assign ctl          = '{accept: accept, pending: pending_q, last: in_row.last_row};

  // Hold the width register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q <= GW_RESET;
    end else if (cfg_we_i) begin
      gw_q <= cfg_wdata_i;
    end
  end

  // Dead border columns on both ends of the chain
  assign own[0]           = '0;
  assign own[ROW_CELLS+1] = '0;

  // Chain of column cells
  for (genvar k = 0; k < ROW_CELLS; k++) begin : g_cell
    lgrs_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (gw_q > gw_t'(k)),
      .cur_i   (in_row.row_cells[k]),
      .ctl_i   (ctl),
      .left_i  (own[k]),
      .right_i (own[k+2]),
      .own_o   (own[k+1]),
      .res_o   (res[k])
    );
    assign nxt_a[k]  = res[k].nxt_a;
    assign nxt_b[k]  = res[k].nxt_b;
    assign diff_a[k] = res[k].diff_a;
    assign diff_b[k] = res[k].diff_b;
  end

  // Columns beyond the implemented cells stay dead
  if (ROW_CELLS < ROW_W) begin : g_pad
    assign nxt_a[ROW_W-1:ROW_CELLS]  = '0;
    assign nxt_b[ROW_W-1:ROW_CELLS]  = '0;
    assign diff_a[ROW_W-1:ROW_CELLS] = '0;
    assign diff_b[ROW_W-1:ROW_CELLS] = '0;
  end

  // Collect change flags in output order
  assign changed_a = |diff_a;
  assign changed_b = |diff_b;
  assign seen_a    = change_seen_q | changed_a;
  assign seen_b    = change_seen_q | (pending_q & changed_a) | changed_b;

  // Build the result entries; the held row goes first when present
  assign ent_a = '{next_row: nxt_a, row_changed: changed_a,
                   frame_changed: seen_a, last_out: 1'b0};
  assign ent_b = '{next_row: nxt_b, row_changed: changed_b,
                   frame_changed: seen_b, last_out: 1'b1};

  always_comb begin
    push.cnt  = 2'd0;
    push.ent0 = pending_q ? ent_a : ent_b;
    push.ent1 = ent_b;
    if (accept) begin
      push.cnt = {1'b0, pending_q} + {1'b0, in_row.last_row};
    end
  end

  // Track the held row and the frame change flag
  always_comb begin
    pending_d     = pending_q;
    change_seen_d = change_seen_q;
    if (accept) begin
      pending_d     = !in_row.last_row;
      change_seen_d = !in_row.last_row && (change_seen_q || (pending_q && changed_a));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q     <= 1'b0;
      change_seen_q <= 1'b0;
    end else begin
      pending_q     <= pending_d;
      change_seen_q <= change_seen_d;
    end
  end

  lgrs_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .room_o  (room),
    .out_row (out_row)
  );

  `LGRS_ASSERT_NXT(a_frame_end_clear, clk_i, rst_ni, accept && in_row.last_row, !pending_q && !change_seen_q, "frame state not cleared at frame end")
  `LGRS_ASSERT_NXT(a_row_held, clk_i, rst_ni, accept && !in_row.last_row, pending_q, "row not held after non-final row")

endmodule

// ===== design/lgrs_cell.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream column cell
// Holds one column of the two buffered rows, trades its bits with the
// neighboring columns and evaluates the rule for both possible results.
// ----------------------------------------------------------------------------
module lgrs_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 cur_i,
  input  lgrs_pkg::cell_ctl_t  ctl_i,
  input  lgrs_pkg::nbr_t       left_i,
  input  lgrs_pkg::nbr_t       right_i,
  output lgrs_pkg::nbr_t       own_o,
  output lgrs_pkg::cell_res_t  res_o
);
  import lgrs_pkg::*;

  logic       above_q, above_d;
  logic       mid_q, mid_d;
  logic       abv_m, mid_m, cur_m;
  logic       up_b;
  logic [3:0] count_a, count_b;
  logic       nxt_a, nxt_b;

  // Mask held and incoming bits with the active width
  assign abv_m = above_q & en_i;
  assign mid_m = mid_q & en_i;
  assign cur_m = cur_i & en_i;
  assign own_o = '{abv: abv_m, mid: mid_m, cur: cur_m};

  // Row above the bottom row is the held row only when one is pending
  assign up_b = ctl_i.pending & mid_m;

  // Count neighbors for the held row and for the incoming row as bottom row
  assign count_a = count_bits({left_i.abv, left_i.mid, left_i.cur, abv_m, cur_m,
                               right_i.abv, right_i.mid, right_i.cur});
  assign count_b = count_bits({ctl_i.pending & left_i.mid, left_i.cur, 1'b0, up_b,
                               1'b0, ctl_i.pending & right_i.mid, right_i.cur, 1'b0});

  // Apply the rule and force inactive columns dead
  assign nxt_a = life_rule(mid_m, count_a) & en_i;
  assign nxt_b = life_rule(cur_m, count_b) & en_i;
  assign res_o = '{nxt_a: nxt_a, diff_a: nxt_a ^ mid_m,
                   nxt_b: nxt_b, diff_b: nxt_b ^ cur_m};

  // Shift the rows down on a transaction; clear at frame end
  always_comb begin
    above_d = above_q;
    mid_d   = mid_q;
    if (ctl_i.accept) begin
      if (ctl_i.last) begin
        above_d = 1'b0;
        mid_d   = 1'b0;
      end else begin
        above_d = up_b;
        mid_d   = cur_m;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      above_q <= 1'b0;
      mid_q   <= 1'b0;
    end else begin
      above_q <= above_d;
      mid_q   <= mid_d;
    end
  end

endmodule

// ===== design/lgrs_out_fifo.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream result queue
// Small queue taking up to two results per cycle and handing out one,
// decoupling the input channel from output backpressure.
// ----------------------------------------------------------------------------
`include "life_generation_row_stream_defines.svh"

module lgrs_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  lgrs_pkg::push_t push_i,
  output logic            room_o,
  lgrs_out_if.source      out_row
);
  import lgrs_pkg::*;

  out_entry_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [PTR_W-1:0] wr_ptr_nx;
  logic             pop;
  out_entry_t       head;

  // Accept input only with room for a full two-result transaction
  assign room_o = count_q <= CNT_W'(FIFO_DEPTH - 2);

  // Present the head entry
  assign head                  = mem_q[rd_ptr_q];
  assign out_row.valid         = count_q != '0;
  assign out_row.next_row      = head.next_row;
  assign out_row.row_changed   = head.row_changed;
  assign out_row.frame_changed = head.frame_changed;
  assign out_row.last_out      = head.last_out;
  assign pop                   = out_row.valid & out_row.ready;

  // Advance pointers and occupancy
  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.cnt);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_i.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Write the pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.ent0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.ent1;
    end
  end

  `LGRS_ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(FIFO_DEPTH), "result queue over depth")
  `LGRS_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_i.cnt != 2'd0, count_q <= CNT_W'(FIFO_DEPTH - 2), "push without room")

endmodule

// ===== tb/sv/life_generation_row_stream_test.sv =====
// ----------------------------------------------------------------------------
// Life generation row stream testbench
// Streams frames of grid rows into the block, predicts every next-generation
// row with a behavioral B3/S23 model, and checks each result in order.
// A directed table covers borders, widths and frame shapes; random frames
// follow under several widths and handshake idling patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module life_generation_row_stream_test;
  import lgrs_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int SEG_ITEMS    = 150;
  localparam int NUM_SEGS     = 13;
  localparam int SETTLE_CYC   = 4;
  localparam int DRAIN_CYC    = 8;
  localparam int HOLD_OFF_CYC = 80;
  localparam int RANDOM_GW    = -1;

  typedef struct {
    row_t       cells;
    logic       last;
    bit         typed;
    out_entry_t want;
    bit         set_gw;
    gw_t        gw;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  gw_t  cfg_wdata_i;

  lgrs_in_if  in_row ();
  lgrs_out_if out_row ();

  life_generation_row_stream uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_row      (in_row),
    .out_row     (out_row)
  );

  // Generation state of the model
  gw_t  width_cfg = GW_RESET;
  row_t row_above = '0;
  row_t row_held  = '0;
  logic held_valid  = 1'b0;
  logic frame_dirty = 1'b0;

  out_entry_t gen_q[$];
  dir_row_t   dir_q[$];

  int mismatches   = 0;
  int cycle_count  = 0;
  int snd_idle_pct = 16;
  int rcv_idle_pct = 87;
  int hold_cycles  = 0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("life_generation_row_stream test failed");
        $finish;
      end
    end
  end

  // Mask of the active columns, saturating at the implemented width
  function automatic row_t width_mask(input gw_t gw);
    int n;
    n = (int'(gw) > ROW_CELLS) ? ROW_CELLS : int'(gw);
    if (n >= ROW_W) return '1;
    return (row_t'(1) << n) - row_t'(1);
  endfunction

  // Next generation of the middle row given its neighbors
  function automatic row_t life_next(input row_t up, input row_t mid, input row_t dn,
                                     input row_t mask);
    row_t u, m, d, res;
    int   cnt;
    u = up & mask;
    m = mid & mask;
    d = dn & mask;
    res = '0;
    for (int k = 0; k < ROW_W; k++) begin
      cnt = int'(u[k]) + int'(d[k]);
      if (k > 0) cnt += int'(u[k-1]) + int'(m[k-1]) + int'(d[k-1]);
      if (k < ROW_W - 1) cnt += int'(u[k+1]) + int'(m[k+1]) + int'(d[k+1]);
      res[k] = (cnt == int'(BIRTH_COUNT)) || (m[k] && cnt == int'(SURVIVE_COUNT));
    end
    return res & mask;
  endfunction

  // Queue one predicted result
  function automatic void push_generation(input row_t up, input row_t mid, input row_t dn,
                                          input row_t mask, input logic last);
    out_entry_t ent;
    ent.next_row    = life_next(up, mid, dn, mask);
    ent.row_changed = (ent.next_row != (mid & mask));
    frame_dirty     = frame_dirty | ent.row_changed;
    ent.frame_changed = frame_dirty;
    ent.last_out    = last;
    gen_q.push_back(ent);
  endfunction

  // Advance the model by one accepted row
  function automatic void step_generation(input row_t cells, input logic last);
    row_t mask, cur;
    mask = width_mask(width_cfg);
    cur  = cells & mask;
    if (held_valid) begin
      push_generation(row_above, row_held, cur, mask, 1'b0);
      row_above = row_held & mask;
    end else begin
      row_above = '0;
    end
    row_held   = cur;
    held_valid = 1'b1;
    if (last) begin
      push_generation(row_above, row_held, '0, mask, 1'b1);
      row_above   = '0;
      row_held    = '0;
      held_valid  = 1'b0;
      frame_dirty = 1'b0;
    end
  endfunction

  task automatic report_mismatch(input string what, input row_t got, input row_t want);
    $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
    mismatches++;
  endtask

  // Offer one row after a random gap and hold it until the transaction
  task automatic send_row(input row_t cells, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_row.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_row.valid     <= 1'b1;
    in_row.row_cells <= cells;
    in_row.last_row  <= last;
    @(posedge clk_i);
    while (!in_row.ready) @(posedge clk_i);
    step_generation(cells, last);
  endtask

  // Write the width once every expected result is out and the block settles
  task automatic write_width(input gw_t gw);
    in_row.valid <= 1'b0;
    @(posedge clk_i);
    while (gen_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= gw;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    width_cfg = gw;
  endtask

  task automatic add_dir(input row_t cells, input logic last, input bit set_gw, input gw_t gw,
                         input bit typed, input row_t nxt, input logic chg,
                         input logic frm);
    dir_row_t r;
    r.cells  = cells;
    r.last   = last;
    r.set_gw = set_gw;
    r.gw     = gw;
    r.typed  = typed;
    r.want.next_row      = nxt;
    r.want.row_changed   = chg;
    r.want.frame_changed = frm;
    r.want.last_out      = 1'b1;
    dir_q.push_back(r);
  endtask

  // Random row content with a mix of densities
  function automatic row_t random_cells();
    row_t a, b;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2, 3:    return a & b & {$urandom, $urandom};
      4:       return a | b;
      5:       return row_t'(1) << $urandom_range(ROW_W - 1);
      default: return a;
    endcase
  endfunction

  // Receive results, check them, and pace ready
  initial begin
    out_entry_t got, want;
    out_row.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_row.valid && out_row.ready) begin
        got.next_row      = out_row.next_row;
        got.row_changed   = out_row.row_changed;
        got.frame_changed = out_row.frame_changed;
        got.last_out      = out_row.last_out;
        if (gen_q.size() == 0) begin
          report_mismatch("unexpected result", got.next_row, '0);
        end else begin
          want = gen_q.pop_front();
          if (got.next_row !== want.next_row)
            report_mismatch("next_row", got.next_row, want.next_row);
          if (got.row_changed !== want.row_changed)
            report_mismatch("row_changed", row_t'(got.row_changed), row_t'(want.row_changed));
          if (got.frame_changed !== want.frame_changed)
            report_mismatch("frame_changed", row_t'(got.frame_changed),
                            row_t'(want.frame_changed));
          if (got.last_out !== want.last_out)
            report_mismatch("last_out", row_t'(got.last_out), row_t'(want.last_out));
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_row.ready <= 1'b0;
      end else begin
        out_row.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // Stimulus
  initial begin
    int seg_gw[NUM_SEGS];
    int rows_left;
    gw_t gw;
    row_t ones;

    seg_gw           = '{64, 1, 0, 127, 3, RANDOM_GW, 63, RANDOM_GW, 64, 2,
                         RANDOM_GW, 100, 64};
    ones             = '1;
    rst_ni           = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_wdata_i      = GW_RESET;
    in_row.valid     = 1'b0;
    in_row.row_cells = '0;
    in_row.last_row  = 1'b0;

    // Single-row frames after reset, then short frames at full width
    add_dir('0, 1'b1, 1'b0, '0, 1'b1, '0, 1'b0, 1'b0);
    add_dir(ones, 1'b1, 1'b0, '0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
    add_dir(64'h8000_0000_0000_0001, 1'b1, 1'b0, '0, 1'b1, '0, 1'b1, 1'b1);
    add_dir(64'h7, 1'b1, 1'b0, '0, 1'b1, 64'h2, 1'b1, 1'b1);
    add_dir(64'h2, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h2, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h2, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h3, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h3, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h2, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h4, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h7, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir('0, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'hC000_0000_0000_0000, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'hC000_0000_0000_0000, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    // Width extremes on single-row frames
    add_dir(ones, 1'b1, 1'b1, gw_t'(0), 1'b1, '0, 1'b0, 1'b0);
    add_dir(ones, 1'b1, 1'b1, gw_t'(127), 1'b1, 64'h7FFF_FFFF_FFFF_FFFE, 1'b1, 1'b1);
    add_dir(ones, 1'b1, 1'b1, gw_t'(3), 1'b1, 64'h2, 1'b1, 1'b1);
    add_dir(ones, 1'b1, 1'b1, gw_t'(1), 1'b1, '0, 1'b1, 1'b1);
    // Narrow the width while a row is held
    add_dir(ones, 1'b0, 1'b1, gw_t'(64), 1'b0, '0, 1'b0, 1'b0);
    add_dir(ones, 1'b0, 1'b1, gw_t'(8), 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'hFF, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b1, gw_t'(64), 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'h5555_5555_5555_5555, 1'b0, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);
    add_dir(64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b0, '0, 1'b0, '0, 1'b0, 1'b0);

    // Hold reset
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed table
    foreach (dir_q[i]) begin
      if (dir_q[i].set_gw) write_width(dir_q[i].gw);
      send_row(dir_q[i].cells, dir_q[i].last);
      if (dir_q[i].typed) gen_q[gen_q.size() - 1] = dir_q[i].want;
    end

    // Random frames, segment by segment; frames may span a width change
    rows_left = 0;
    for (int s = 0; s < NUM_SEGS; s++) begin
      if (s < 4) begin
        snd_idle_pct = 16;
        rcv_idle_pct = 87;
      end else if (s < 9) begin
        snd_idle_pct = 87;
        rcv_idle_pct = 16;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      gw = (seg_gw[s] == RANDOM_GW) ? gw_t'($urandom_range(2, ROW_CELLS - 1))
                                    : gw_t'(seg_gw[s]);
      write_width(gw);
      // Stall the output long enough to back up the input
      if (s == 9) hold_cycles = HOLD_OFF_CYC;
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if (rows_left == 0)
          rows_left = ($urandom_range(9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
        send_row(random_cells(), rows_left == 1);
        rows_left--;
      end
    end

    // Drain and finish
    in_row.valid <= 1'b0;
    @(posedge clk_i);
    while (gen_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("life_generation_row_stream test passed");
    end else begin
      $display("life_generation_row_stream test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/lgrs_pkg.sv
design/lgrs_in_if.sv
design/lgrs_out_if.sv
design/lgrs_cell.sv
design/lgrs_out_fifo.sv
design/life_generation_row_stream.sv
tb/sv/life_generation_row_stream_test.sv
